// ----- design/ttfu_pkg.sv -----
// Shared types, constants and helpers for the textured triangle fragment unit.
// Used by ttfu_divider and textured_triangle_fragment_unit; no dependencies.
package ttfu_pkg;

    localparam int MUL_W = 25;
    localparam int ACC_W = 2 * MUL_W;
    localparam int NUM_W = 49;
    localparam int EXT_W = 52;
    localparam int Q_W   = 17;

    localparam logic [1:0] MODE_VERTEX = 2'd0;
    localparam logic [1:0] MODE_TEXEL  = 2'd1;
    localparam logic [1:0] MODE_PIXEL  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic CFG_TEX_WIDTH  = 1'b0;
    localparam logic CFG_TEX_HEIGHT = 1'b1;

    localparam logic [Q_W-1:0]          ONE_Q16   = 17'h10000;
    localparam logic [23:0]             DEPTH_FAR = 24'hFFFFFF;
    localparam logic signed [ACC_W-1:0] AREA_MIN  = 50'sd66;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } div_status_t;

    function automatic logic signed [MUL_W-1:0] uext(input logic [23:0] x);
        return $signed({1'b0, x});
    endfunction

    function automatic logic [7:0] chan(input logic [23:0] t, input logic [1:0] c);
        logic [7:0] r;
        case (c)
            2'd0:    r = t[23:16];
            2'd1:    r = t[15:8];
            default: r = t[7:0];
        endcase
        return r;
    endfunction

endpackage

// ----- design/ttfu_divider.sv -----
// Serial restoring divider: floor(num * 65536 / den), saturating at 1.0 in Q16.
// One quotient bit per cycle. Depends on ttfu_pkg.
module ttfu_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ttfu_pkg::NUM_W-1:0] num,
    input  logic [ttfu_pkg::NUM_W-1:0] den,
    output ttfu_pkg::div_status_t     status
);
    import ttfu_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [3:0]       cnt_reg;
    logic [NUM_W:0]   rem_reg;
    logic [NUM_W-1:0] den_reg;
    logic [Q_W-1:0]   quot_reg;
    logic [NUM_W:0]   rem_shift;
    logic             ge;

    assign rem_shift   = {rem_reg[NUM_W-1:0], 1'b0};
    assign ge          = rem_shift >= {1'b0, den_reg};
    assign status.done = done_reg;
    assign status.quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                den_reg <= den;
                rem_reg <= {1'b0, num};
                cnt_reg <= '0;
                if (num >= den)
                begin
                    quot_reg <= ONE_Q16;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
                else
                begin
                    quot_reg <= '0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
                quot_reg <= {quot_reg[Q_W-2:0], ge};
                cnt_reg  <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- design/textured_triangle_fragment_unit.sv -----
// Textured triangle fragment unit: vertex, texel and depth stores, one shared
// 25x25 multiply-accumulate unit under a sequencer. Depends on ttfu_pkg, ttfu_divider.
// Vertex load, texel load, depth clear, a small triangle and a pixel outside the
// triangle finish without the divider; a full textured pixel runs the two 16-step
// weight divisions and 41 serial multiply-accumulate steps, and any output stall adds
// to it. One request at a time. After reset a clearing pass sets every depth entry
// to far, during which no request is taken.
module textured_triangle_fragment_unit #(
    parameter int FRAME_WIDTH  = 512,
    parameter int FRAME_HEIGHT = 512,
    parameter int TEX_DIM      = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [1:0]         vertex_slot,
    input  logic signed [22:0] vert_x,
    input  logic signed [22:0] vert_y,
    input  logic [23:0]        vert_depth,
    input  logic [15:0]        vert_u,
    input  logic [15:0]        vert_v,
    input  logic [15:0]        vert_shade,
    input  logic [8:0]         pixel_x,
    input  logic [8:0]         pixel_y,
    input  logic [15:0]        texel_index,
    input  logic [23:0]        texel_rgb,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               pixel_write,
    output logic [8:0]         out_x,
    output logic [8:0]         out_y,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data
);
    import ttfu_pkg::*;

    localparam int DEPTH_ENTRIES = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int DW            = $clog2(DEPTH_ENTRIES);
    localparam int TEX_ENTRIES   = TEX_DIM * TEX_DIM;
    localparam int TW            = $clog2(TEX_ENTRIES);
    localparam int CW            = $clog2(TEX_DIM + 1);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_AREA   = 4'd2;
    localparam logic [3:0] ST_E1     = 4'd3;
    localparam logic [3:0] ST_E2     = 4'd4;
    localparam logic [3:0] ST_COVER  = 4'd5;
    localparam logic [3:0] ST_DIV1   = 4'd6;
    localparam logic [3:0] ST_DIV2   = 4'd7;
    localparam logic [3:0] ST_INTERP = 4'd8;
    localparam logic [3:0] ST_ZTEST  = 4'd9;
    localparam logic [3:0] ST_FX     = 4'd10;
    localparam logic [3:0] ST_FY     = 4'd11;
    localparam logic [3:0] ST_TEX    = 4'd12;
    localparam logic [3:0] ST_BIL    = 4'd13;
    localparam logic [3:0] ST_EMIT   = 4'd14;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_ADD  = 2'd2;
    localparam logic [1:0] OP_SUB  = 2'd3;

    logic [3:0]  state_reg;
    logic [2:0]  step_reg;
    logic [1:0]  qsel_reg;
    logic [1:0]  ch_reg;
    logic [DW-1:0] clr_reg;

    logic [8:0]  tw_reg;
    logic [8:0]  th_reg;

    logic signed [22:0] cx_reg [3];
    logic signed [22:0] cy_reg [3];
    logic [23:0] cd_reg [3];
    logic [15:0] cu_reg [3];
    logic [15:0] cv_reg [3];
    logic [15:0] cs_reg [3];

    logic [23:0] depth_mem [DEPTH_ENTRIES];
    logic [23:0] texel_mem [TEX_ENTRIES];
    logic [23:0] dep_rd_reg;
    logic [23:0] tex_rd_reg;

    logic [8:0]  px_reg;
    logic [8:0]  py_reg;
    logic [DW-1:0] pix_addr_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] area_reg;
    logic signed [ACC_W-1:0] e1_reg;
    logic signed [ACC_W-1:0] e2_reg;
    logic [NUM_W-1:0] mag_reg;
    logic [NUM_W-1:0] e2n_reg;
    logic [Q_W-1:0] w0_reg;
    logic [Q_W-1:0] w1_reg;
    logic [Q_W-1:0] w2_reg;
    logic [23:0] z_reg;
    logic [15:0] u_reg;
    logic [15:0] v_reg;
    logic [15:0] sh_reg;
    logic [CW-1:0] x0_reg;
    logic [CW-1:0] x1_reg;
    logic [CW-1:0] y0_reg;
    logic [CW-1:0] y1_reg;
    logic [15:0] tx_reg;
    logic [15:0] ty_reg;
    logic [23:0] tex_reg [4];
    logic [23:0] r0_reg;
    logic [23:0] r1_reg;
    logic [7:0]  t_reg;
    logic [7:0]  rgb_reg [3];
    logic        res_write_reg;

    logic        out_valid_reg;
    logic        out_write_reg;
    logic [8:0]  out_x_reg;
    logic [8:0]  out_y_reg;
    logic [7:0]  out_r_reg;
    logic [7:0]  out_g_reg;
    logic [7:0]  out_b_reg;

    logic        in_accept;
    logic        in_frame;
    logic        tex_index_ok;
    logic [DW-1:0] in_dep_addr;
    logic [CW-1:0] tw_c;
    logic [CW-1:0] th_c;

    logic signed [23:0] dbx, dcx, dby, dcy, dqx, dqy;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [ACC_W-1:0] prod;
    logic [1:0]  acc_op;
    logic [Q_W-1:0] w_sel;
    logic [23:0] val_sel;
    logic [Q_W-1:0] omtx;
    logic [Q_W-1:0] omty;

    logic signed [EXT_W-1:0] area_x, e0_x, e1_x, e2_x, n0, n1, n2, mag_x;
    logic        area_neg;
    logic        cover_ok;
    logic        area_small;

    logic        div_start;
    logic [NUM_W-1:0] div_num;
    logic [NUM_W-1:0] div_den;
    div_status_t div_st;

    logic [CW-1:0] x0_n, y0_n, x0p1, y0p1;
    logic [CW-1:0] tex_col, tex_row;

    logic        dep_we;
    logic        dep_re;
    logic [DW-1:0] dep_addr;
    logic [23:0] dep_wdata;
    logic        tex_we;
    logic        tex_re;
    logic [TW-1:0] tex_addr;

    ttfu_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_st)
    );

    assign in_stall     = (state_reg != ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign in_frame     = (32'(pixel_x) < FRAME_WIDTH) && (32'(pixel_y) < FRAME_HEIGHT);
    assign tex_index_ok = 32'(texel_index) < TEX_ENTRIES;
    assign in_dep_addr  = DW'(32'(pixel_y) * 32'(FRAME_WIDTH) + 32'(pixel_x));

    assign tw_c = (tw_reg < 9'd2) ? CW'(2) :
                  (32'(tw_reg) > TEX_DIM) ? CW'(TEX_DIM) : CW'(tw_reg);
    assign th_c = (th_reg < 9'd2) ? CW'(2) :
                  (32'(th_reg) > TEX_DIM) ? CW'(TEX_DIM) : CW'(th_reg);

    assign dbx = 24'(cx_reg[1]) - 24'(cx_reg[0]);
    assign dcx = 24'(cx_reg[2]) - 24'(cx_reg[0]);
    assign dby = 24'(cy_reg[1]) - 24'(cy_reg[0]);
    assign dcy = 24'(cy_reg[2]) - 24'(cy_reg[0]);
    assign dqx = $signed({7'd0, px_reg, 8'h80}) - 24'(cx_reg[0]);
    assign dqy = $signed({7'd0, py_reg, 8'h80}) - 24'(cy_reg[0]);

    assign omtx = ONE_Q16 - {1'b0, tx_reg};
    assign omty = ONE_Q16 - {1'b0, ty_reg};

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    w_sel = w0_reg;
            2'd1:    w_sel = w1_reg;
            default: w_sel = w2_reg;
        endcase
        case (qsel_reg)
            2'd0:    val_sel = cd_reg[step_reg[1:0]];
            2'd1:    val_sel = 24'(cu_reg[step_reg[1:0]]);
            2'd2:    val_sel = 24'(cv_reg[step_reg[1:0]]);
            default: val_sel = 24'(cs_reg[step_reg[1:0]]);
        endcase
    end

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        acc_op = OP_HOLD;
        case (state_reg)
            ST_AREA:
            begin
                mul_a  = step_reg[0] ? MUL_W'(dcx) : MUL_W'(dbx);
                mul_b  = step_reg[0] ? MUL_W'(dby) : MUL_W'(dcy);
                acc_op = step_reg[0] ? OP_SUB : OP_LOAD;
            end
            ST_E1:
            begin
                mul_a  = step_reg[0] ? MUL_W'(dcx) : MUL_W'(dqx);
                mul_b  = step_reg[0] ? MUL_W'(dqy) : MUL_W'(dcy);
                acc_op = step_reg[0] ? OP_SUB : OP_LOAD;
            end
            ST_E2:
            begin
                mul_a  = step_reg[0] ? MUL_W'(dqx) : MUL_W'(dbx);
                mul_b  = step_reg[0] ? MUL_W'(dby) : MUL_W'(dqy);
                acc_op = step_reg[0] ? OP_SUB : OP_LOAD;
            end
            ST_INTERP:
            begin
                mul_a  = uext(24'(w_sel));
                mul_b  = uext(val_sel);
                acc_op = (step_reg == 3'd0) ? OP_LOAD : OP_ADD;
            end
            ST_FX:
            begin
                mul_a  = uext(24'(u_reg));
                mul_b  = uext(24'(tw_c) - 24'd1);
                acc_op = OP_LOAD;
            end
            ST_FY:
            begin
                mul_a  = uext(24'(ONE_Q16 - {1'b0, v_reg}));
                mul_b  = uext(24'(th_c) - 24'd1);
                acc_op = OP_LOAD;
            end
            ST_BIL:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = uext(24'(chan(tex_reg[0], ch_reg)));
                        mul_b = uext(24'(omtx));
                    end
                    3'd1:
                    begin
                        mul_a = uext(24'(chan(tex_reg[1], ch_reg)));
                        mul_b = uext(24'(tx_reg));
                    end
                    3'd2:
                    begin
                        mul_a = uext(24'(chan(tex_reg[2], ch_reg)));
                        mul_b = uext(24'(omtx));
                    end
                    3'd3:
                    begin
                        mul_a = uext(24'(chan(tex_reg[3], ch_reg)));
                        mul_b = uext(24'(tx_reg));
                    end
                    3'd4:
                    begin
                        mul_a = uext(r0_reg);
                        mul_b = uext(24'(omty));
                    end
                    3'd5:
                    begin
                        mul_a = uext(r1_reg);
                        mul_b = uext(24'(ty_reg));
                    end
                    default:
                    begin
                        mul_a = uext(24'(t_reg));
                        mul_b = uext(24'(sh_reg));
                    end
                endcase
                acc_op = (step_reg[0] && step_reg != 3'd7) ? OP_ADD : OP_LOAD;
            end
            default:
            begin
                acc_op = OP_HOLD;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        case (acc_op)
            OP_LOAD: acc_next = prod;
            OP_ADD:  acc_next = acc_reg + prod;
            OP_SUB:  acc_next = acc_reg - prod;
            default: acc_next = acc_reg;
        endcase
    end

    assign area_small = (acc_next > -AREA_MIN) && (acc_next < AREA_MIN);

    assign area_neg = area_reg[ACC_W-1];
    assign area_x   = EXT_W'(area_reg);
    assign e1_x     = EXT_W'(e1_reg);
    assign e2_x     = EXT_W'(e2_reg);
    assign e0_x     = area_x - e1_x - e2_x;
    assign n0       = area_neg ? -e0_x : e0_x;
    assign n1       = area_neg ? -e1_x : e1_x;
    assign n2       = area_neg ? -e2_x : e2_x;
    assign mag_x    = area_neg ? -area_x : area_x;
    assign cover_ok = !n0[EXT_W-1] && !n1[EXT_W-1] && !n2[EXT_W-1];

    assign div_start = ((state_reg == ST_COVER) && cover_ok) ||
                       ((state_reg == ST_DIV1) && div_st.done);
    assign div_num   = (state_reg == ST_COVER) ? NUM_W'(n1) : e2n_reg;
    assign div_den   = (state_reg == ST_COVER) ? NUM_W'(mag_x) : mag_reg;

    assign x0_n = CW'(prod[ACC_W-1:16]);
    assign y0_n = CW'(prod[ACC_W-1:16]);
    assign x0p1 = x0_n + CW'(1);
    assign y0p1 = y0_n + CW'(1);

    assign tex_col = step_reg[0] ? x1_reg : x0_reg;
    assign tex_row = step_reg[1] ? y1_reg : y0_reg;

    always_comb
    begin
        dep_we    = 1'b0;
        dep_re    = 1'b0;
        dep_addr  = in_dep_addr;
        dep_wdata = DEPTH_FAR;
        case (state_reg)
            ST_CLEAR:
            begin
                dep_we   = 1'b1;
                dep_addr = clr_reg;
            end
            ST_IDLE:
            begin
                dep_we = in_accept && in_frame && (mode == MODE_CLEAR);
                dep_re = in_accept && in_frame && (mode == MODE_PIXEL);
            end
            ST_ZTEST:
            begin
                dep_we    = z_reg < dep_rd_reg;
                dep_addr  = pix_addr_reg;
                dep_wdata = z_reg;
            end
            default:
            begin
                dep_we = 1'b0;
            end
        endcase
    end

    assign tex_we   = (state_reg == ST_IDLE) && in_accept && (mode == MODE_TEXEL) && tex_index_ok;
    assign tex_re   = (state_reg == ST_TEX) && !step_reg[2];
    assign tex_addr = tex_we ? TW'(texel_index) :
                      TW'(32'(tex_row) * 32'(TEX_DIM) + 32'(tex_col));

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            depth_mem[dep_addr] <= dep_wdata;
        end
        else if (dep_re)
        begin
            dep_rd_reg <= depth_mem[dep_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tex_we)
        begin
            texel_mem[tex_addr] <= texel_rgb;
        end
        else if (tex_re)
        begin
            tex_rd_reg <= texel_mem[tex_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg <= 9'd256;
            th_reg <= 9'd256;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_TEX_WIDTH)
            begin
                tw_reg <= cfg_data;
            end
            else if (cfg_index == CFG_TEX_HEIGHT)
            begin
                th_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= '0;
            qsel_reg      <= '0;
            ch_reg        <= '0;
            clr_reg       <= '0;
            res_write_reg <= 1'b0;
            acc_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cx_reg[i] <= '0;
                cy_reg[i] <= '0;
                cd_reg[i] <= '0;
                cu_reg[i] <= '0;
                cv_reg[i] <= '0;
                cs_reg[i] <= '0;
            end
        end
        else
        begin
            acc_reg <= acc_next;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + DW'(1);
                    if (clr_reg == DW'(DEPTH_ENTRIES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        res_write_reg <= 1'b0;
                        px_reg        <= pixel_x;
                        py_reg        <= pixel_y;
                        pix_addr_reg  <= in_dep_addr;
                        step_reg      <= '0;
                        state_reg     <= ST_EMIT;
                        if ((mode == MODE_VERTEX) && (vertex_slot != 2'd3))
                        begin
                            cx_reg[vertex_slot] <= vert_x;
                            cy_reg[vertex_slot] <= vert_y;
                            cd_reg[vertex_slot] <= vert_depth;
                            cu_reg[vertex_slot] <= vert_u;
                            cv_reg[vertex_slot] <= vert_v;
                            cs_reg[vertex_slot] <= vert_shade;
                        end
                        if ((mode == MODE_PIXEL) && in_frame)
                        begin
                            state_reg <= ST_AREA;
                        end
                    end
                end
                ST_AREA:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg[0])
                    begin
                        area_reg <= acc_next;
                        step_reg <= '0;
                        state_reg <= area_small ? ST_EMIT : ST_E1;
                    end
                end
                ST_E1:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg[0])
                    begin
                        e1_reg    <= acc_next;
                        step_reg  <= '0;
                        state_reg <= ST_E2;
                    end
                end
                ST_E2:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg[0])
                    begin
                        e2_reg    <= acc_next;
                        step_reg  <= '0;
                        state_reg <= ST_COVER;
                    end
                end
                ST_COVER:
                begin
                    mag_reg   <= NUM_W'(mag_x);
                    e2n_reg   <= NUM_W'(n2);
                    state_reg <= cover_ok ? ST_DIV1 : ST_EMIT;
                end
                ST_DIV1:
                begin
                    if (div_st.done)
                    begin
                        w1_reg    <= div_st.quot;
                        state_reg <= ST_DIV2;
                    end
                end
                ST_DIV2:
                begin
                    if (div_st.done)
                    begin
                        w2_reg    <= div_st.quot;
                        w0_reg    <= ONE_Q16 - w1_reg - div_st.quot;
                        step_reg  <= '0;
                        qsel_reg  <= '0;
                        state_reg <= ST_INTERP;
                    end
                end
                ST_INTERP:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd2)
                    begin
                        step_reg <= '0;
                        qsel_reg <= qsel_reg + 2'd1;
                        case (qsel_reg)
                            2'd0:
                            begin
                                z_reg     <= acc_next[39:16];
                                state_reg <= ST_ZTEST;
                            end
                            2'd1:
                            begin
                                u_reg <= acc_next[31:16];
                            end
                            2'd2:
                            begin
                                v_reg <= acc_next[31:16];
                            end
                            default:
                            begin
                                sh_reg    <= acc_next[31:16];
                                state_reg <= ST_FX;
                            end
                        endcase
                    end
                end
                ST_ZTEST:
                begin
                    state_reg <= (z_reg < dep_rd_reg) ? ST_INTERP : ST_EMIT;
                end
                ST_FX:
                begin
                    x0_reg    <= x0_n;
                    tx_reg    <= prod[15:0];
                    x1_reg    <= (x0p1 < tw_c - CW'(1)) ? x0p1 : tw_c - CW'(1);
                    state_reg <= ST_FY;
                end
                ST_FY:
                begin
                    y0_reg    <= y0_n;
                    ty_reg    <= prod[15:0];
                    y1_reg    <= (y0p1 < th_c - CW'(1)) ? y0p1 : th_c - CW'(1);
                    step_reg  <= '0;
                    state_reg <= ST_TEX;
                end
                ST_TEX:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg != 3'd0)
                    begin
                        tex_reg[step_reg[1:0] - 2'd1] <= tex_rd_reg;
                    end
                    if (step_reg == 3'd4)
                    begin
                        step_reg  <= '0;
                        ch_reg    <= '0;
                        state_reg <= ST_BIL;
                    end
                end
                ST_BIL:
                begin
                    step_reg <= step_reg + 3'd1;
                    case (step_reg)
                        3'd1:    r0_reg <= acc_next[23:0];
                        3'd3:    r1_reg <= acc_next[23:0];
                        3'd5:    t_reg  <= acc_next[39:32];
                        3'd6:
                        begin
                            rgb_reg[ch_reg] <= acc_next[23:16];
                            step_reg        <= '0;
                            ch_reg          <= ch_reg + 2'd1;
                            if (ch_reg == 2'd2)
                            begin
                                res_write_reg <= 1'b1;
                                state_reg     <= ST_EMIT;
                            end
                        end
                        default: r0_reg <= r0_reg;
                    endcase
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_write_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_r_reg     <= '0;
            out_g_reg     <= '0;
            out_b_reg     <= '0;
        end
        else if ((state_reg == ST_EMIT) && (!out_valid_reg || !out_stall))
        begin
            out_valid_reg <= 1'b1;
            out_write_reg <= res_write_reg;
            out_x_reg     <= res_write_reg ? px_reg : 9'd0;
            out_y_reg     <= res_write_reg ? py_reg : 9'd0;
            out_r_reg     <= res_write_reg ? rgb_reg[0] : 8'd0;
            out_g_reg     <= res_write_reg ? rgb_reg[1] : 8'd0;
            out_b_reg     <= res_write_reg ? rgb_reg[2] : 8'd0;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_write = out_write_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign red         = out_r_reg;
    assign green       = out_g_reg;
    assign blue        = out_b_reg;

endmodule
